FILE: rtl/sha1_pkg.sv
// ============================================================================
// sha1_pkg: shared constants and round helpers
// Initial chaining values, round constants and the round function.
// ============================================================================
`default_nettype none

package sha1_pkg;

    localparam int unsigned LenPos     = 56;
    localparam int unsigned Rounds     = 80;
    localparam int unsigned CountW     = 61;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hefcdab89;
    localparam logic [31:0] H2 = 32'h98badcfe;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hc3d2e1f0;

    localparam logic [31:0] K0 = 32'h5a827999;
    localparam logic [31:0] K1 = 32'h6ed9eba1;
    localparam logic [31:0] K2 = 32'h8f1bbcdc;
    localparam logic [31:0] K3 = 32'hca62c1d6;

    localparam logic [7:0] PadByte = 8'h80;

    localparam logic OpData   = 1'b0;
    localparam logic OpFinish = 1'b1;

    function automatic logic [31:0] round_f(input logic [6:0] r,
                                            input logic [31:0] b,
                                            input logic [31:0] c,
                                            input logic [31:0] d);
        if (r < 7'd20) begin
            round_f = (b & c) | (~b & d);
        end else if (r < 7'd40) begin
            round_f = b ^ c ^ d;
        end else if (r < 7'd60) begin
            round_f = (b & c) | (b & d) | (c & d);
        end else begin
            round_f = b ^ c ^ d;
        end
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] r);
        if (r < 7'd20) begin
            round_k = K0;
        end else if (r < 7'd40) begin
            round_k = K1;
        end else if (r < 7'd60) begin
            round_k = K2;
        end else begin
            round_k = K3;
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/sha1_round.sv
// ============================================================================
// sha1_round: iterative SHA-1 compression
// Runs one round per cycle, while i_init is low, on a 16-word schedule window, then folds the
// working variables into the chaining words.
// ============================================================================
`default_nettype none

module sha1_round (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic                  i_init,
    input  wire logic [511:0]          i_block,
    output logic                       o_busy,
    output logic [159:0]               o_chain
);

    logic [31:0] r_h [5];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] r_w [16];
    logic [6:0]  r_rnd;
    logic        r_busy;
    logic [31:0] w_x;
    logic [31:0] w_t;
    logic [31:0] w_mix;

    assign w_mix = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign w_x   = (r_rnd < 7'd16) ? r_w[0] : {w_mix[30:0], w_mix[31]};
    assign w_t   = {r_a[26:0], r_a[31:27]} + sha1_pkg::round_f(r_rnd, r_b, r_c, r_d)
                   + r_e + sha1_pkg::round_k(r_rnd) + w_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rnd  <= '0;
            r_h[0] <= sha1_pkg::H0;
            r_h[1] <= sha1_pkg::H1;
            r_h[2] <= sha1_pkg::H2;
            r_h[3] <= sha1_pkg::H3;
            r_h[4] <= sha1_pkg::H4;
        end else if (i_init) begin
            r_h[0] <= sha1_pkg::H0;
            r_h[1] <= sha1_pkg::H1;
            r_h[2] <= sha1_pkg::H2;
            r_h[3] <= sha1_pkg::H3;
            r_h[4] <= sha1_pkg::H4;
        end else if (i_start && !r_busy) begin
            r_busy <= 1'b1;
            r_rnd  <= '0;
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
            for (int j = 0; j < 16; j++) begin
                r_w[j] <= i_block[511 - 32 * j -: 32];
            end
        end else if (r_busy) begin
            if (r_rnd == 7'(sha1_pkg::Rounds)) begin
                r_busy <= 1'b0;
                r_h[0] <= r_h[0] + r_a;
                r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e;
            end else begin
                r_rnd <= r_rnd + 7'd1;
                for (int j = 0; j < 15; j++) begin
                    r_w[j] <= r_w[j + 1];
                end
                r_w[15] <= w_x;
                r_e <= r_d;
                r_d <= r_c;
                r_c <= {r_b[1:0], r_b[31:2]};
                r_b <= r_a;
                r_a <= w_t;
            end
        end
    end

    assign o_busy  = r_busy;
    assign o_chain = {r_h[0], r_h[1], r_h[2], r_h[3], r_h[4]};

    a_rnd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rnd <= 7'(sha1_pkg::Rounds)) else $error("round counter overrun");
    a_idle_rnd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !r_busy && !i_init) |=> (r_busy && r_rnd == 7'd0))
        else $error("compression did not start");
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_rnd == 7'(sha1_pkg::Rounds) && !i_init) |=> !r_busy)
        else $error("compression did not end");

endmodule

`default_nettype wire

FILE: rtl/sha1_stream_hasher_core.sv
// ============================================================================
// sha1_stream_hasher_core: byte-stream SHA-1 hasher
// One byte per transaction; a finish transaction pads and emits the digest.
// ============================================================================
// A data transaction that completes a 64-byte block starts a compression;
// each compression holds the block from its start request while it starts
// the single round unit, runs 80 rounds at one per cycle, folds into the
// chaining words and hands back.
// A finish transaction fills padding one byte per cycle between compressions,
// writes the length, runs one or two compressions in all, then presents
// five digest words in order, index 0 first, with last_word set on index 4.
// Input stall is high while any of this work is pending.
`default_nettype none

module sha1_stream_hasher_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_op,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_last_word
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_COMP = 6'b000010,
        ST_PAD  = 6'b000100,
        ST_LEN  = 6'b001000,
        ST_FIN  = 6'b010000,
        ST_OUT  = 6'b100000
    } t_state;

    t_state                      r_state;
    logic [511:0]                r_blk;
    logic [5:0]                  r_fill;
    logic [sha1_pkg::CountW-1:0] r_count;
    logic                        r_go;
    logic                        r_fin;
    logic                        r_xtra;
    logic [2:0]                  r_idx;
    logic                        r_init;
    logic                        w_busy;
    logic [159:0]                w_chain;
    logic [63:0]                 w_bits;
    logic                        w_acc;

    assign w_bits = {r_count, 3'b000};
    assign w_acc  = i_valid && !o_stall;

    sha1_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go),
        .i_init  (r_init),
        .i_block (r_blk),
        .o_busy  (w_busy),
        .o_chain (w_chain)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_blk   <= '0;
            r_fill  <= '0;
            r_count <= '0;
            r_go    <= 1'b0;
            r_fin   <= 1'b0;
            r_xtra  <= 1'b0;
            r_idx   <= '0;
            r_init  <= 1'b0;
        end else begin
            r_go   <= 1'b0;
            r_init <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (w_acc) begin
                        if (i_op == sha1_pkg::OpData) begin
                            r_blk   <= {r_blk[503:0], i_data_byte};
                            r_fill  <= r_fill + 6'd1;
                            r_count <= r_count + 61'd1;
                            if (r_fill == 6'd63) begin
                                r_go    <= 1'b1;
                                r_fin   <= 1'b0;
                                r_state <= ST_COMP;
                            end
                        end else begin
                            r_blk   <= {r_blk[503:0], sha1_pkg::PadByte};
                            r_fill  <= r_fill + 6'd1;
                            r_fin   <= 1'b1;
                            r_state <= ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    if (r_fill == 6'(sha1_pkg::LenPos)) begin
                        r_state <= ST_LEN;
                    end else if (r_fill == 6'd0 && !r_xtra) begin
                        r_go    <= 1'b1;
                        r_xtra  <= 1'b1;
                        r_state <= ST_COMP;
                    end else begin
                        r_blk  <= {r_blk[503:0], 8'h00};
                        r_fill <= r_fill + 6'd1;
                    end
                end
                ST_LEN: begin
                    r_blk   <= {r_blk[447:0], w_bits};
                    r_fill  <= '0;
                    r_xtra  <= 1'b0;
                    r_go    <= 1'b1;
                    r_state <= ST_FIN;
                end
                ST_COMP: begin
                    if (!r_go && !w_busy) begin
                        r_state <= r_fin ? ST_PAD : ST_IDLE;
                    end
                end
                ST_FIN: begin
                    if (!r_go && !w_busy) begin
                        r_idx   <= '0;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!i_stall) begin
                        if (r_idx == 3'd4) begin
                            r_state <= ST_IDLE;
                            r_fill  <= '0;
                            r_count <= '0;
                            r_fin   <= 1'b0;
                            r_init  <= 1'b1;
                        end else begin
                            r_idx <= r_idx + 3'd1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_stall       = (r_state != ST_IDLE) || r_init;
    assign o_valid       = (r_state == ST_OUT);
    assign o_digest_word = w_chain[159 - 32 * r_idx -: 32];
    assign o_word_index  = r_idx;
    assign o_last_word   = (r_idx == 3'd4);

    a_no_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("output while accepting");
    a_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_idx <= 3'd4)) else $error("digest index overrun");
    a_unit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_busy) else $error("round unit busy in idle");

endmodule

`default_nettype wire
